FILE: rtl/core/fpbs_pkg.sv
// Shared types and constants for the binary64 power-by-squaring block.
package fpbs_pkg;

   localparam int unsigned MantW = 53;
   localparam int unsigned ProdW = 2 * MantW;

   localparam logic [63:0] ONE_BITS       = 64'h3FF0_0000_0000_0000;
   localparam logic [62:0] NEAR_ZERO_MAG  = 63'h3E7A_D7F2_9ABC_AF48;
   localparam logic [63:0] QUIET_BIT      = 64'h0008_0000_0000_0000;
   localparam logic [63:0] DEFAULT_NAN    = 64'hFFF8_0000_0000_0000;
   localparam logic [10:0] EXP_ALL_ONES   = 11'h7FF;

   typedef enum logic [0:0] {
      OP_MUL,
      OP_RECIP
   } fpbs_op_type;

   typedef struct packed {
      logic        start;
      fpbs_op_type op;
   } fpbs_cmd_type;

   typedef enum logic [3:0] {
      F_IDLE,
      F_MUL,
      F_PRENORM,
      F_DIV,
      F_NORM_R,
      F_NORM_L,
      F_DENORM,
      F_ROUND
   } fpbs_fstate_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEEK,
      S_SQ,
      S_SQ_WAIT,
      S_MUL,
      S_MUL_WAIT,
      S_FIN,
      S_DIV,
      S_DIV_WAIT,
      S_OUT
   } fpbs_state_type;

endpackage

FILE: rtl/core/fpbs_fpu.sv
// Iterative binary64 multiply and reciprocal unit with shared normalize and round.
module fpbs_fpu (
   input  logic                 clock,
   input  logic                 reset,
   input  fpbs_pkg::fpbs_cmd_type cmd,
   input  logic [63:0]          op_a,
   input  logic [63:0]          op_b,
   output logic                 done,
   output logic [63:0]          result
);
   import fpbs_pkg::*;

   fpbs_fstate_type state_ff, state_in;
   logic              sign_ff, sign_in;
   logic signed [13:0] exp_ff, exp_in;
   logic [ProdW-1:0]  p_ff, p_in;
   logic              sticky_ff, sticky_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [MantW-1:0]  am_ff, am_in, bm_ff, bm_in;
   logic [MantW:0]    rem_ff, rem_in;
   logic [63:0]       res_ff, res_in;
   logic              done_ff, done_in;

   logic [10:0] ea, eb, ea_eff, eb_eff;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [MantW-1:0] ma, mb;
   logic [26:0] xa, yb;
   logic [53:0] pp;
   logic [5:0]  sh;
   logic [ProdW-1:0] pp_sh;
   logic        ge;
   logic [ProdW-1:0] q_sh;
   logic [MantW-1:0] mant;
   logic        rnd_g, rnd_s, rnd_up;
   logic [MantW:0] sum;
   logic [MantW-1:0] m2;
   logic signed [13:0] e2;

   assign ea     = op_a[62:52];
   assign eb     = op_b[62:52];
   assign ea_eff = (ea == 11'd0) ? 11'd1 : ea;
   assign eb_eff = (eb == 11'd0) ? 11'd1 : eb;
   assign ma     = {ea != 11'd0, op_a[51:0]};
   assign mb     = {eb != 11'd0, op_b[51:0]};
   assign a_nan  = (ea == EXP_ALL_ONES) && (op_a[51:0] != 52'd0);
   assign b_nan  = (eb == EXP_ALL_ONES) && (op_b[51:0] != 52'd0);
   assign a_inf  = (ea == EXP_ALL_ONES) && (op_a[51:0] == 52'd0);
   assign b_inf  = (eb == EXP_ALL_ONES) && (op_b[51:0] == 52'd0);
   assign a_zero = (op_a[62:0] == 63'd0);
   assign b_zero = (op_b[62:0] == 63'd0);

   // one 27x27 partial product per cycle
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: begin
            xa = am_ff[26:0];
            yb = bm_ff[26:0];
            sh = 6'd0;
         end
         2'd1: begin
            xa = {1'b0, am_ff[52:27]};
            yb = bm_ff[26:0];
            sh = 6'd27;
         end
         2'd2: begin
            xa = am_ff[26:0];
            yb = {1'b0, bm_ff[52:27]};
            sh = 6'd27;
         end
         default: begin
            xa = {1'b0, am_ff[52:27]};
            yb = {1'b0, bm_ff[52:27]};
            sh = 6'd54;
         end
      endcase
   end

   assign pp    = xa * yb;
   assign pp_sh = {52'd0, pp} << sh;

   assign ge   = rem_ff >= {1'b0, bm_ff};
   assign q_sh = {p_ff[ProdW-2:0], ge};

   assign mant   = p_ff[104:52];
   assign rnd_g  = p_ff[51];
   assign rnd_s  = (|p_ff[50:0]) | sticky_ff;
   assign rnd_up = rnd_g & (rnd_s | mant[0]);
   assign sum    = {1'b0, mant} + {{MantW{1'b0}}, rnd_up};
   assign m2     = sum[MantW] ? sum[MantW:1] : sum[MantW-1:0];
   assign e2     = exp_ff + $signed({13'd0, sum[MantW]});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (cmd.start) begin
               if (cmd.op == OP_MUL) begin
                  if (!(a_nan || b_nan || a_inf || b_inf || a_zero || b_zero)) begin
                     state_in = F_MUL;
                  end
               end else if (!(b_nan || b_inf || b_zero)) begin
                  state_in = F_PRENORM;
               end
            end
         end
         F_MUL:     if (cnt_ff[1:0] == 2'd3) state_in = F_NORM_R;
         F_PRENORM: if (bm_ff[MantW-1]) state_in = F_DIV;
         F_DIV:     if (cnt_ff == 6'd55) state_in = F_NORM_R;
         F_NORM_R:  state_in = F_NORM_L;
         F_NORM_L: begin
            if (p_ff[104] || exp_ff <= 14'sd1 || p_ff == '0) state_in = F_DENORM;
         end
         F_DENORM:  if (exp_ff >= 14'sd1) state_in = F_ROUND;
         F_ROUND:   state_in = F_IDLE;
         default:   state_in = F_IDLE;
      endcase
   end

   always_comb begin
      sign_in   = sign_ff;
      exp_in    = exp_ff;
      p_in      = p_ff;
      sticky_in = sticky_ff;
      cnt_in    = cnt_ff;
      am_in     = am_ff;
      bm_in     = bm_ff;
      rem_in    = rem_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (cmd.start) begin
               p_in      = '0;
               sticky_in = 1'b0;
               cnt_in    = '0;
               am_in     = ma;
               bm_in     = mb;
               if (cmd.op == OP_MUL) begin
                  sign_in = op_a[63] ^ op_b[63];
                  exp_in  = $signed({3'd0, ea_eff}) + $signed({3'd0, eb_eff}) - 14'sd1023;
                  done_in = 1'b1;
                  priority if (a_nan) begin
                     res_in = op_a | QUIET_BIT;
                  end else if (b_nan) begin
                     res_in = op_b | QUIET_BIT;
                  end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                     res_in = DEFAULT_NAN;
                  end else if (a_inf || b_inf) begin
                     res_in = {op_a[63] ^ op_b[63], EXP_ALL_ONES, 52'd0};
                  end else if (a_zero || b_zero) begin
                     res_in = {op_a[63] ^ op_b[63], 63'd0};
                  end else begin
                     done_in = 1'b0;
                  end
               end else begin
                  sign_in = op_b[63];
                  exp_in  = $signed({3'd0, eb_eff});
                  done_in = 1'b1;
                  priority if (b_nan) begin
                     res_in = op_b | QUIET_BIT;
                  end else if (b_inf) begin
                     res_in = {op_b[63], 63'd0};
                  end else if (b_zero) begin
                     res_in = {op_b[63], EXP_ALL_ONES, 52'd0};
                  end else begin
                     done_in = 1'b0;
                  end
               end
            end
         end
         F_MUL: begin
            p_in   = p_ff + pp_sh;
            cnt_in = cnt_ff + 6'd1;
         end
         F_PRENORM: begin
            if (!bm_ff[MantW-1]) begin
               bm_in  = {bm_ff[MantW-2:0], 1'b0};
               exp_in = exp_ff - 14'sd1;
            end else begin
               exp_in = 14'sd2046 - exp_ff;
               rem_in = {2'b01, 52'd0};
               cnt_in = '0;
            end
         end
         F_DIV: begin
            rem_in = (ge ? (rem_ff - {1'b0, bm_ff}) : rem_ff) << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd55) begin
               p_in      = q_sh << 49;
               sticky_in = (ge ? (rem_ff - {1'b0, bm_ff}) : rem_ff) != '0;
            end else begin
               p_in = q_sh;
            end
         end
         F_NORM_R: begin
            if (p_ff[105]) begin
               p_in      = p_ff >> 1;
               sticky_in = sticky_ff | p_ff[0];
               exp_in    = exp_ff + 14'sd1;
            end
         end
         F_NORM_L: begin
            if (!p_ff[104] && exp_ff > 14'sd1 && p_ff != '0) begin
               p_in   = p_ff << 1;
               exp_in = exp_ff - 14'sd1;
            end
         end
         F_DENORM: begin
            if (exp_ff < -14'sd60) begin
               sticky_in = sticky_ff | (|p_ff);
               p_in      = '0;
               exp_in    = 14'sd1;
            end else if (exp_ff < 14'sd1) begin
               sticky_in = sticky_ff | p_ff[0];
               p_in      = p_ff >> 1;
               exp_in    = exp_ff + 14'sd1;
            end
         end
         F_ROUND: begin
            done_in = 1'b1;
            if (e2 >= 14'sd2047) begin
               res_in = {sign_ff, EXP_ALL_ONES, 52'd0};
            end else begin
               res_in = {sign_ff, (m2[MantW-1] ? e2[10:0] : 11'd0), m2[51:0]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sign_ff   <= sign_in;
      exp_ff    <= exp_in;
      p_ff      <= p_in;
      sticky_ff <= sticky_in;
      cnt_ff    <= cnt_in;
      am_ff     <= am_in;
      bm_ff     <= bm_in;
      rem_ff    <= rem_in;
      res_ff    <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

FILE: rtl/core/float_power_by_squaring.sv
// Binary64 base raised to a signed 32-bit integer power by squaring.
// Trivial cases go straight to the output; else leading zeros of |power| are skipped, each
// lower bit costs a squaring, each lower set bit a multiply, and a negative power ends in a
// reciprocal. Multiplies and the reciprocal share one iterative unit (27x27 multiplier,
// 1-bit divider); subnormal operands and results add normalizing or denormalizing shifts.
// One item at a time; req_tready is high only while idle. Synchronous active-high reset.
module float_power_by_squaring (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // [63:0] base_bits, [95:64] power
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [63:0] result_bits, [64] domain_error, [71:65] zero
);
   import fpbs_pkg::*;

   fpbs_state_type state_ff, state_in;
   logic [63:0] base_ff, base_in;
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        err_ff, err_in;
   logic [31:0] mag_ff, mag_in;
   logic [4:0]  left_ff, left_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [64:0] rsp_data_ff, rsp_data_in;

   fpbs_cmd_type cmd;
   logic         fpu_done;
   logic [63:0]  fpu_result;
   logic [63:0]  fpu_b;

   logic        accept;
   logic [63:0] in_base;
   logic [31:0] in_power, in_mag;
   logic        in_neg, in_near;
   logic        out_free;

   assign in_base  = req_tdata[63:0];
   assign in_power = req_tdata[95:64];
   assign in_neg   = in_power[31];
   assign in_mag   = in_neg ? (~in_power + 32'd1) : in_power;
   assign in_near  = in_base[62:0] < NEAR_ZERO_MAG;
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign fpu_b = (state_ff == S_MUL) ? base_ff : acc_ff;

   fpbs_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .op_a   (acc_ff),
      .op_b   (fpu_b),
      .done   (fpu_done),
      .result (fpu_result)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((in_neg && in_near) || in_power == 32'd0 || (!in_neg && in_mag == 32'd1)) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_SEEK;
               end
            end
         end
         S_SEEK:     if (mag_ff[31]) state_in = (left_ff == 5'd0) ? S_FIN : S_SQ;
         S_SQ:       state_in = S_SQ_WAIT;
         S_SQ_WAIT: begin
            if (fpu_done) begin
               priority if (mag_ff[31])      state_in = S_MUL;
               else if (left_ff == 5'd0)     state_in = S_FIN;
               else                          state_in = S_SQ;
            end
         end
         S_MUL:      state_in = S_MUL_WAIT;
         S_MUL_WAIT: if (fpu_done) state_in = (left_ff == 5'd0) ? S_FIN : S_SQ;
         S_FIN:      state_in = (neg_ff && acc_ff[62:0] != 63'd0) ? S_DIV : S_OUT;
         S_DIV:      state_in = S_DIV_WAIT;
         S_DIV_WAIT: if (fpu_done) state_in = S_OUT;
         S_OUT:      if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      base_in      = base_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      mag_in       = mag_ff;
      left_in      = left_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.start    = 1'b0;
      cmd.op       = OP_MUL;
      req_tready   = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               base_in = in_base;
               neg_in  = in_neg;
               mag_in  = in_mag;
               left_in = 5'd31;
               err_in  = 1'b0;
               acc_in  = in_base;
               priority if (in_neg && in_near) begin
                  acc_in = 64'd0;
                  err_in = 1'b1;
               end else if (in_power == 32'd0) begin
                  acc_in = ONE_BITS;
               end else begin
                  acc_in = in_base;
               end
            end
         end
         S_SEEK: begin
            if (!mag_ff[31]) begin
               mag_in  = mag_ff << 1;
               left_in = left_ff - 5'd1;
            end
         end
         S_SQ: begin
            cmd.start = 1'b1;
            mag_in    = mag_ff << 1;
            left_in   = left_ff - 5'd1;
         end
         S_SQ_WAIT:  if (fpu_done) acc_in = fpu_result;
         S_MUL:      cmd.start = 1'b1;
         S_MUL_WAIT: if (fpu_done) acc_in = fpu_result;
         S_FIN: begin
            if (neg_ff && acc_ff[62:0] == 63'd0) acc_in = {acc_ff[63], EXP_ALL_ONES, 52'd0};
         end
         S_DIV: begin
            cmd.start = 1'b1;
            cmd.op    = OP_RECIP;
         end
         S_DIV_WAIT: if (fpu_done) acc_in = fpu_result;
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {err_ff, acc_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      err_ff      <= err_in;
      mag_ff      <= mag_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

endmodule
